### hw/rtl/m3inv_pkg.sv
// Shared constants and types for the 3x3 matrix inverse
package m3inv_pkg;

	// element format, signed fixed point
	localparam int ELEM_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int NUM_ELEMS = 9;
	localparam int IDX_BITS  = $clog2(NUM_ELEMS);

	// exact intermediate widths
	localparam int PROD_BITS = 2 * ELEM_BITS;          // 2x2 cofactor
	localparam int DET_BITS  = 3 * ELEM_BITS + 2;      // determinant
	localparam int NUM_BITS  = PROD_BITS + 2 * FRAC_BITS;  // scaled cofactor
	localparam int QUO_BITS  = ELEM_BITS + 1;          // quotient bits kept before rounding
	localparam int REM_BITS  = (DET_BITS > NUM_BITS - QUO_BITS) ?
		DET_BITS : NUM_BITS - QUO_BITS;

	// pipeline depths
	localparam int FRONT_LAT = 5;                      // cofactors and determinant
	localparam int DIV_LAT   = QUO_BITS + 4;           // divider lane
	localparam int PIPE_LEN  = FRONT_LAT + DIV_LAT;

	typedef logic [IDX_BITS-1:0]          idx_t;
	typedef logic signed [ELEM_BITS-1:0]  elem_t;
	typedef logic signed [PROD_BITS-1:0]  cof_t;
	typedef logic signed [DET_BITS-1:0]   det_t;

	// one divider lane's result
	typedef struct packed {
		logic [ELEM_BITS-1:0] val;
		logic                 sat;
	} quot_t;

	// one result item
	typedef struct packed {
		logic [NUM_ELEMS-1:0][ELEM_BITS-1:0] r;
		logic                                singular;
		logic                                overflow;
	} res_t;

	// cofactor (row, col) of the adjugate = a[p]*a[q] - a[r]*a[s], row-major
	localparam idx_t COF_IDX [NUM_ELEMS][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
	};

	// cofactors that pair with the top row in the determinant
	localparam idx_t DET_COF [3] = '{4'd0, 4'd3, 4'd6};

endpackage

### hw/rtl/m3inv_mat_if.sv
// Matrix input channel
interface m3inv_mat_if;
	logic                  valid;
	logic                  ready;
	m3inv_pkg::elem_t      a00, a01, a02;
	m3inv_pkg::elem_t      a10, a11, a12;
	m3inv_pkg::elem_t      a20, a21, a22;

	modport source (
		output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		input  ready
	);
	modport sink (
		input  valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		output ready
	);
endinterface

### hw/rtl/m3inv_res_if.sv
// Inverse result channel
interface m3inv_res_if;
	logic                  valid;
	logic                  ready;
	m3inv_pkg::elem_t      r00, r01, r02;
	m3inv_pkg::elem_t      r10, r11, r12;
	m3inv_pkg::elem_t      r20, r21, r22;
	logic                  singular;
	logic                  overflow;

	modport source (
		output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular, overflow,
		input  ready
	);
	modport sink (
		input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular, overflow,
		output ready
	);
endinterface

### hw/rtl/m3inv_cof_lane.sv
// One 2x2 cofactor: x0*x1 - x2*x3, two stages
module m3inv_cof_lane (
	input  logic              clk,
	input  logic              en,
	input  m3inv_pkg::elem_t  x0,
	input  m3inv_pkg::elem_t  x1,
	input  m3inv_pkg::elem_t  x2,
	input  m3inv_pkg::elem_t  x3,
	output m3inv_pkg::cof_t   cof
);

	m3inv_pkg::cof_t pos_s1;
	m3inv_pkg::cof_t neg_s1;
	m3inv_pkg::cof_t cof_s2;

	// products, then difference (exact, cannot wrap)
	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= x0 * x1;
			neg_s1 <= x2 * x3;
			cof_s2 <= pos_s1 - neg_s1;
		end
	end

	assign cof = cof_s2;

endmodule

### hw/rtl/m3inv_det.sv
// Determinant from the top row and its three cofactors, three stages
module m3inv_det (
	input  logic              clk,
	input  logic              en,
	input  m3inv_pkg::elem_t  row [3],
	input  m3inv_pkg::cof_t   cof [3],
	output m3inv_pkg::det_t   det
);

	localparam int EB = m3inv_pkg::ELEM_BITS;
	localparam int TB = 3 * EB;
	localparam int DB = m3inv_pkg::DET_BITS;

	logic signed [2*EB:0]   lo_s3   [3];
	logic signed [2*EB-1:0] hi_s3   [3];
	logic signed [TB-1:0]   term_s4 [3];
	m3inv_pkg::det_t        det_s5;

	// element times cofactor, split into low (unsigned) and high (signed) halves
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				lo_s3[k]   <= row[k] * $signed({1'b0, cof[k][EB-1:0]});
				hi_s3[k]   <= row[k] * $signed(cof[k][2*EB-1:EB]);
				term_s4[k] <= $signed({hi_s3[k], {EB{1'b0}}}) + TB'(lo_s3[k]);
			end
			det_s5 <= DB'(term_s4[0]) + DB'(term_s4[1]) + DB'(term_s4[2]);
		end
	end

	assign det = det_s5;

endmodule

### hw/rtl/m3inv_div_lane.sv
// Rounded, saturated quotient cofactor * 2^(2*frac) / det.
// Restoring division, one quotient bit per stage.
module m3inv_div_lane (
	input  logic              clk,
	input  logic              en,
	input  m3inv_pkg::cof_t   cof,
	input  m3inv_pkg::det_t   det,
	output m3inv_pkg::quot_t  quot
);

	localparam int EB = m3inv_pkg::ELEM_BITS;
	localparam int FB = m3inv_pkg::FRAC_BITS;
	localparam int PB = m3inv_pkg::PROD_BITS;
	localparam int DB = m3inv_pkg::DET_BITS;
	localparam int NB = m3inv_pkg::NUM_BITS;
	localparam int QB = m3inv_pkg::QUO_BITS;
	localparam int RB = m3inv_pkg::REM_BITS;

	localparam logic [QB:0] LIM_NEG = {{(QB + 1 - EB){1'b0}}, 1'b1, {(EB - 1){1'b0}}};
	localparam logic [QB:0] LIM_POS = LIM_NEG - (QB + 1)'(1);

	// magnitudes
	logic [PB-1:0] cmag;
	logic [NB-1:0] num;
	logic [DB-1:0] dmag;

	always_comb begin
		cmag = cof[PB-1] ? -cof : cof;
		num  = {cmag, {(2 * FB){1'b0}}};
		dmag = det[DB-1] ? -det : det;
	end

	logic [RB-1:0] rem_s1;
	logic [QB-1:0] low_s1;
	logic [DB-1:0] dmag_s1;
	logic          neg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= RB'(num[NB-1:QB]);
			low_s1  <= num[QB-1:0];
			dmag_s1 <= dmag;
			neg_s1  <= cof[PB-1] ^ det[DB-1];
		end
	end

	// step stages: index 0 is the pre-check stage, index k+1 follows step k
	logic [RB-1:0] rem_st    [QB+1];
	logic [QB-1:0] low_st    [QB+1];
	logic [QB-1:0] q_st      [QB+1];
	logic [DB-1:0] dmag_st   [QB+1];
	logic          neg_st    [QB+1];
	logic          presat_st [QB+1];

	logic [RB-1:0] nxt_rem [QB];
	logic          fits    [QB];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RB:0] trial;
		logic [RB:0] diff;
		assign trial      = {rem_st[k], low_st[k][QB-1]};
		assign diff       = trial - (RB + 1)'(dmag_st[k]);
		assign fits[k]    = trial >= (RB + 1)'(dmag_st[k]);
		assign nxt_rem[k] = fits[k] ? diff[RB-1:0] : trial[RB-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// quotient of 2^QB or more: saturates whatever follows
			rem_st[0]    <= rem_s1;
			low_st[0]    <= low_s1;
			q_st[0]      <= '0;
			dmag_st[0]   <= dmag_s1;
			neg_st[0]    <= neg_s1;
			presat_st[0] <= rem_s1 >= RB'(dmag_s1);
			for (int k = 0; k < QB; k++) begin
				rem_st[k+1]    <= nxt_rem[k];
				low_st[k+1]    <= {low_st[k][QB-2:0], 1'b0};
				q_st[k+1]      <= {q_st[k][QB-2:0], fits[k]};
				dmag_st[k+1]   <= dmag_st[k];
				neg_st[k+1]    <= neg_st[k];
				presat_st[k+1] <= presat_st[k];
			end
		end
	end

	// round half away from zero on the magnitude
	logic          up;
	logic [QB:0]   qr_sr;
	logic          neg_sr;
	logic          presat_sr;

	assign up = {rem_st[QB], 1'b0} >= (RB + 1)'(dmag_st[QB]);

	always_ff @(posedge clk) begin
		if (en) begin
			qr_sr     <= (QB + 1)'(q_st[QB]) + (QB + 1)'(up);
			neg_sr    <= neg_st[QB];
			presat_sr <= presat_st[QB];
		end
	end

	// saturate and apply sign
	logic [QB:0]          lim;
	logic                 sat;
	logic [QB:0]          mag;
	logic [EB-1:0]        val;
	m3inv_pkg::quot_t     quot_so;

	always_comb begin
		lim = neg_sr ? LIM_NEG : LIM_POS;
		sat = presat_sr || (qr_sr > lim);
		mag = sat ? lim : qr_sr;
		val = neg_sr ? -mag[EB-1:0] : mag[EB-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_so.val <= val;
			quot_so.sat <= sat;
		end
	end

	assign quot = quot_so;

endmodule

### hw/rtl/matrix3x3_inverse.sv
// 3x3 matrix inverse, signed Q16.16 elements, by adjugate and determinant.
// mat: one item is a whole matrix a00..a22, accepted when valid and ready.
// inv: one item is the inverse r00..r22 plus singular and overflow flags.
// Nine cofactor lanes, a determinant unit and nine divider lanes work side
// by side; a merge stage zeroes the result for a singular matrix and ORs
// the lanes' saturation flags into overflow.
// Throughput: one matrix per clock cycle while the skid register is empty.
// Pipeline: from acceptance to inv.valid the depth is set by the
// restoring divider in each lane, which resolves one of 33 quotient bits
// per stage, plus 5 stages for cofactors and determinant and 5 more for
// magnitudes, range check, rounding, saturation and the output register.
// Stall: with inv.ready low the output register holds its item and a skid
// register takes one more; mat.ready then drops and the whole pipeline
// freezes until the skid register drains.
// Reset (arst_n low) clears all valid bits; items in flight are dropped and
// mat.ready is high straight after reset.
module matrix3x3_inverse (
	input  logic                clk,
	input  logic                arst_n,
	m3inv_mat_if.sink           mat,
	m3inv_res_if.source         inv
);

	localparam int NE   = m3inv_pkg::NUM_ELEMS;
	localparam int DL   = m3inv_pkg::DIV_LAT;
	localparam int PIPE = m3inv_pkg::PIPE_LEN;

	logic en;

	m3inv_pkg::elem_t  elem    [NE];
	m3inv_pkg::elem_t  row_s1  [3];
	m3inv_pkg::elem_t  row_s2  [3];
	m3inv_pkg::cof_t   cof_s2  [NE];
	m3inv_pkg::cof_t   cof_s3  [NE];
	m3inv_pkg::cof_t   cof_s4  [NE];
	m3inv_pkg::cof_t   cof_s5  [NE];
	m3inv_pkg::cof_t   det_cof [3];
	m3inv_pkg::det_t   det_s5;
	m3inv_pkg::quot_t  quot    [NE];

	logic [PIPE:1]     vld_s;
	logic [DL-1:0]     sing_s;

	m3inv_pkg::res_t   res_d;
	m3inv_pkg::res_t   out_q;
	m3inv_pkg::res_t   skid_q;
	logic              out_vld_q;
	logic              skid_vld_q;
	logic              any_sat;

	// pipeline moves whenever the skid register is free
	assign en        = !skid_vld_q;
	assign mat.ready = en;

	assign elem[0] = mat.a00;
	assign elem[1] = mat.a01;
	assign elem[2] = mat.a02;
	assign elem[3] = mat.a10;
	assign elem[4] = mat.a11;
	assign elem[5] = mat.a12;
	assign elem[6] = mat.a20;
	assign elem[7] = mat.a21;
	assign elem[8] = mat.a22;

	// cofactor lanes
	for (genvar i = 0; i < NE; i++) begin : g_cof
		m3inv_cof_lane u_cof (
			.clk (clk),
			.en  (en),
			.x0  (elem[m3inv_pkg::COF_IDX[i][0]]),
			.x1  (elem[m3inv_pkg::COF_IDX[i][1]]),
			.x2  (elem[m3inv_pkg::COF_IDX[i][2]]),
			.x3  (elem[m3inv_pkg::COF_IDX[i][3]]),
			.cof (cof_s2[i])
		);
	end

	// top row and cofactors, delayed to meet the determinant
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				row_s1[k] <= elem[k];
				row_s2[k] <= row_s1[k];
			end
			for (int i = 0; i < NE; i++) begin
				cof_s3[i] <= cof_s2[i];
				cof_s4[i] <= cof_s3[i];
				cof_s5[i] <= cof_s4[i];
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_det_cof
		assign det_cof[k] = cof_s2[m3inv_pkg::DET_COF[k]];
	end

	m3inv_det u_det (
		.clk (clk),
		.en  (en),
		.row (row_s2),
		.cof (det_cof),
		.det (det_s5)
	);

	// divider lanes
	for (genvar i = 0; i < NE; i++) begin : g_div
		m3inv_div_lane u_div (
			.clk  (clk),
			.en   (en),
			.cof  (cof_s5[i]),
			.det  (det_s5),
			.quot (quot[i])
		);
	end

	// item valid along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE-1:1], mat.valid};
		end
	end

	// singular flag rides alongside the divider lanes
	always_ff @(posedge clk) begin
		if (en) begin
			sing_s <= {sing_s[DL-2:0], det_s5 == '0};
		end
	end

	// merge the lanes
	always_comb begin
		any_sat        = 1'b0;
		res_d.singular = sing_s[DL-1];
		for (int i = 0; i < NE; i++) begin
			res_d.r[i] = sing_s[DL-1] ? '0 : quot[i].val;
			any_sat    = any_sat | quot[i].sat;
		end
		res_d.overflow = any_sat && !sing_s[DL-1];
	end

	// output register with one-item skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (!out_vld_q || inv.ready) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || inv.ready) begin
			out_vld_q <= vld_s[PIPE];
		end else if (vld_s[PIPE]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (!out_vld_q || inv.ready) begin
				out_q <= skid_q;
			end
		end else if (!out_vld_q || inv.ready) begin
			out_q <= res_d;
		end else begin
			skid_q <= res_d;
		end
	end

	assign inv.valid    = out_vld_q;
	assign inv.r00      = out_q.r[0];
	assign inv.r01      = out_q.r[1];
	assign inv.r02      = out_q.r[2];
	assign inv.r10      = out_q.r[3];
	assign inv.r11      = out_q.r[4];
	assign inv.r12      = out_q.r[5];
	assign inv.r20      = out_q.r[6];
	assign inv.r21      = out_q.r[7];
	assign inv.r22      = out_q.r[8];
	assign inv.singular = out_q.singular;
	assign inv.overflow = out_q.overflow;

`ifndef ASSERT_OFF
	// the skid register only ever holds an item behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register full while output register empty");

	// a singular result is all zero and never flagged as saturated
	a_singular_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(inv.valid && inv.singular) |-> (!inv.overflow && out_q.r == '0))
		else $error("singular result with nonzero elements or overflow");

	// the pipeline freezes while stalled
	a_frozen_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline moved during a stall");
`endif

endmodule

### dv/m3inv_inverse_checker.sv
// Watches both channels of the 3x3 inverse, predicts each inverse exactly
// and compares it field by field with what the block returns.
module m3inv_inverse_checker
	import m3inv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	m3inv_mat_if    mat,
	m3inv_res_if    inv,
	output int      errors,
	output int      pending,
	output int      checked,
	output int      singulars,
	output int      saturations
);

	localparam int WIDE      = 192;

	typedef logic signed [WIDE-1:0] wide_t;

	typedef struct {
		elem_t e [NUM_ELEMS];
		logic  singular;
		logic  overflow;
	} inverse_t;

	inverse_t expected_inverses [$];

	// exact adjugate over determinant, rounded half away from zero, saturated
	function automatic inverse_t predict_inverse(input elem_t a [NUM_ELEMS]);
		wide_t           m   [3][3];
		wide_t           adj [3][3];
		wide_t           det;
		wide_t           num;
		logic [WIDE-1:0] nmag, dmag, quo, rem, lim;
		logic            neg;
		inverse_t        res;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = wide_t'(a[3*i+j]);
		// adj(i,j) is the cofactor of element (j,i)
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				adj[i][j] = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
					- m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
		det = m[0][0] * adj[0][0] + m[0][1] * adj[1][0] + m[0][2] * adj[2][0];
		res.singular = (det == 0);
		res.overflow = 1'b0;
		for (int k = 0; k < NUM_ELEMS; k++) begin
			if (res.singular) begin
				res.e[k] = '0;
			end else begin
				num  = adj[k/3][k%3] <<< (2 * FRAC_BITS);
				neg  = num[WIDE-1] ^ det[WIDE-1];
				nmag = num[WIDE-1] ? -num : num;
				dmag = det[WIDE-1] ? -det : det;
				quo  = nmag / dmag;
				rem  = nmag % dmag;
				if ((rem << 1) >= dmag)
					quo = quo + 1;
				lim = neg ? (WIDE'(1) << (ELEM_BITS - 1)) : ((WIDE'(1) << (ELEM_BITS - 1)) - 1);
				if (quo > lim) begin
					quo          = lim;
					res.overflow = 1'b1;
				end
				res.e[k] = neg ? -quo[ELEM_BITS-1:0] : quo[ELEM_BITS-1:0];
			end
		end
		return res;
	endfunction

	function automatic void report(input string field, input logic [ELEM_BITS-1:0] want,
			input logic [ELEM_BITS-1:0] got);
		errors++;
		$display("%0t: inverse %0d, %s: expected %h, got %h",
			$time, checked, field, want, got);
	endfunction

	// predict on every accepted matrix, check every accepted inverse
	always @(posedge clk) begin : watch
		elem_t    a   [NUM_ELEMS];
		elem_t    got [NUM_ELEMS];
		inverse_t want;
		if (!arst_n) begin
			expected_inverses.delete();
			errors      = 0;
			checked     = 0;
			singulars   = 0;
			saturations = 0;
		end else begin
			if (mat.valid && mat.ready) begin
				a = '{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12,
					mat.a20, mat.a21, mat.a22};
				expected_inverses.push_back(predict_inverse(a));
			end
			if (inv.valid && inv.ready) begin
				if (expected_inverses.size() == 0) begin
					errors++;
					$display("%0t: inverse item with no matrix outstanding", $time);
				end else begin
					want = expected_inverses.pop_front();
					got  = '{inv.r00, inv.r01, inv.r02, inv.r10, inv.r11, inv.r12,
						inv.r20, inv.r21, inv.r22};
					for (int k = 0; k < NUM_ELEMS; k++)
						if (got[k] !== want.e[k])
							report($sformatf("r%0d%0d", k / 3, k % 3), want.e[k], got[k]);
					if (inv.singular !== want.singular)
						report("singular", ELEM_BITS'(want.singular),
							ELEM_BITS'(inv.singular));
					if (inv.overflow !== want.overflow)
						report("overflow", ELEM_BITS'(want.overflow),
							ELEM_BITS'(inv.overflow));
					if (want.singular)
						singulars++;
					if (want.overflow)
						saturations++;
				end
				checked++;
			end
		end
		pending = expected_inverses.size();
	end

endmodule

### dv/tb_top.sv
module tb_top;
	import m3inv_pkg::*;

	localparam int    CYCLE_LIMIT = 200000;
	localparam int    DRAIN       = 60;
	localparam elem_t MAXV        = 32'sh7fffffff;
	localparam elem_t MINV        = 32'sh80000000;
	localparam elem_t ONE         = 32'sh00010000;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   hold_off;
	int   sent;
	int   errors, pending, checked, singulars, saturations;
	int unsigned cycle_count = 0;

	m3inv_mat_if mat_ch ();
	m3inv_res_if inv_ch ();

	matrix3x3_inverse DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat_ch),
		.inv    (inv_ch)
	);

	m3inv_inverse_checker inverse_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.mat         (mat_ch),
		.inv         (inv_ch),
		.errors      (errors),
		.pending     (pending),
		.checked     (checked),
		.singulars   (singulars),
		.saturations (saturations)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		inv_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			inv_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic elem_t rand_span(input int span);
		return elem_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic elem_t rand_extreme();
		case ($urandom_range(7))
			0: return MINV;
			1: return MAXV;
			2: return 0;
			3: return 1;
			4: return -1;
			5: return ONE;
			6: return -ONE;
			default: return elem_t'($urandom);
		endcase
	endfunction

	// mostly well-formed matrices with meaningful inverses, plus singular,
	// near-singular, full-range and extreme ones
	function automatic void gen_matrix(output elem_t m [NUM_ELEMS]);
		int kind, r1, r2, r3, s;
		kind = $urandom_range(99);
		r1   = $urandom_range(2);
		r2   = (r1 + 1 + $urandom_range(1)) % 3;
		r3   = 3 - r1 - r2;
		for (int k = 0; k < NUM_ELEMS; k++)
			m[k] = rand_span(1 << 20);
		if (kind < 20) begin
			for (int k = 0; k < NUM_ELEMS; k++)
				m[k] = elem_t'($urandom);
		end else if (kind < 50) begin
			for (int k = 0; k < NUM_ELEMS; k++)
				m[k] = rand_span(8 * 65536);
		end else if (kind < 62) begin
			// diagonally dominant, inverse near unity scale
			for (int k = 0; k < NUM_ELEMS; k++)
				m[k] = rand_span(65536);
			for (int k = 0; k < 3; k++)
				m[4*k] = m[4*k] + ($urandom_range(1) ? 4 * ONE : -4 * ONE);
		end else if (kind < 78) begin
			// singular by construction, small enough not to wrap
			s = $urandom_range(6) - 3;
			case ($urandom_range(4))
				0: for (int j = 0; j < 3; j++) m[3*r2+j] = m[3*r1+j];
				1: for (int j = 0; j < 3; j++) m[3*r2+j] = m[3*r1+j] * s;
				2: for (int j = 0; j < 3; j++) m[3*r3+j] = m[3*r1+j] + m[3*r2+j];
				// a whole zero row or a whole zero column
				3: for (int j = 0; j < 3; j++) begin
					if (s < 0)
						m[3*r1+j] = 0;
					else
						m[3*j+r1] = 0;
				end
				default: for (int i = 0; i < 3; i++) m[3*i+r2] = m[3*i+r1];
			endcase
		end else if (kind < 88) begin
			// tiny elements: huge inverses, saturation
			for (int k = 0; k < NUM_ELEMS; k++)
				m[k] = rand_span(255);
		end else if (kind < 94) begin
			for (int k = 0; k < NUM_ELEMS; k++)
				m[k] = rand_span(1 << 24);
		end else begin
			for (int k = 0; k < NUM_ELEMS; k++)
				m[k] = rand_extreme();
		end
	endfunction

	// offer one matrix, with random idle cycles first; returns at the
	// falling edge after it is accepted, valid still high
	task automatic offer_matrix(input elem_t m [NUM_ELEMS]);
		while ($urandom_range(99) < send_idle_pct) begin
			mat_ch.valid <= 1'b0;
			@(negedge clk);
		end
		mat_ch.valid <= 1'b1;
		mat_ch.a00   <= m[0];
		mat_ch.a01   <= m[1];
		mat_ch.a02   <= m[2];
		mat_ch.a10   <= m[3];
		mat_ch.a11   <= m[4];
		mat_ch.a12   <= m[5];
		mat_ch.a20   <= m[6];
		mat_ch.a21   <= m[7];
		mat_ch.a22   <= m[8];
		do
			@(posedge clk);
		while (!mat_ch.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic offer_random(input int count);
		elem_t m [NUM_ELEMS];
		for (int n = 0; n < count; n++) begin
			gen_matrix(m);
			offer_matrix(m);
		end
	endtask

	initial begin : stimulus
		elem_t m [NUM_ELEMS];
		int    idle_set  [4];
		int    stall_set [4];
		idle_set       = '{0, 66, 0, 37};
		stall_set      = '{0, 0, 66, 37};
		arst_n         = 1'b0;
		hold_off       = 1'b0;
		sent           = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		mat_ch.valid   = 1'b0;
		{mat_ch.a00, mat_ch.a01, mat_ch.a02} = '0;
		{mat_ch.a10, mat_ch.a11, mat_ch.a12} = '0;
		{mat_ch.a20, mat_ch.a21, mat_ch.a22} = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: identity, zero, extremes, saturation edges, rounding ties
		m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};              offer_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                    offer_matrix(m);
		m = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}; offer_matrix(m);
		m = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}; offer_matrix(m);
		m = '{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV};           offer_matrix(m);
		m = '{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV};           offer_matrix(m);
		m = '{MAXV, MINV, 0, MINV, MAXV, 1, 0, 1, MAXV};     offer_matrix(m);
		m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                    offer_matrix(m);
		m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};                   offer_matrix(m);
		// quotient just past the top of the range, then exactly the bottom
		m = '{2, 0, 0, 0, ONE, 0, 0, 0, ONE};                offer_matrix(m);
		m = '{-2, 0, 0, 0, ONE, 0, 0, 0, ONE};               offer_matrix(m);
		m = '{3, 0, 0, 0, ONE, 0, 0, 0, ONE};                offer_matrix(m);
		// halfway quotients, positive and negative
		m = '{0, -32'sd131072, 0, 32'sd65536, 3, 0, 0, 0, 1};  offer_matrix(m);
		m = '{0, -32'sd131072, 0, 32'sd65536, -3, 0, 0, 0, 1}; offer_matrix(m);
		// equal rows, zero column: singular
		m = '{5 * ONE, -3, 77, 5 * ONE, -3, 77, 9, 8, 7};    offer_matrix(m);
		m = '{0, 1, 2, 0, 3, 4, 0, 5, 6};                    offer_matrix(m);
		// zero pivot, permutation
		m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};              offer_matrix(m);
		m = '{2 * ONE, 0, 0, 0, 4 * ONE, 0, 0, 0, ONE / 2};  offer_matrix(m);
		m = '{32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
			32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA};
		offer_matrix(m);
		m = '{-ONE, 2 * ONE, -7 * ONE, 0, 3 * ONE, ONE / 4, 0, 0, -5 * ONE};
		offer_matrix(m);
		m = '{ONE, ONE, 0, ONE, 0, ONE, 0, ONE, ONE};        offer_matrix(m);

		// random phases; the first also holds the receiver off so the block backs up
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_set[p];
			recv_stall_pct = stall_set[p];
			if (p == 0) begin
				fork
					offer_random(420);
					begin
						repeat (30) @(posedge clk);
						hold_off = 1'b1;
						repeat (300) @(posedge clk);
						hold_off = 1'b0;
					end
				join
			end else begin
				offer_random(400);
			end
		end
		mat_ch.valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("Sent %0d matrices under four idle and stall mixes and one long back-pressure stretch;",
			sent);
		$display("checked %0d inverses, %0d singular and %0d saturated.",
			checked, singulars, saturations);
		if (errors == 0 && pending == 0 && checked == sent) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
